// ===== rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg
// shared types for the integer set table: opcodes, states, control bundles
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int ValueW = 32;
	localparam int CountW = 7;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} ist_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ist_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} ist_ctl_t;

	typedef struct packed {
		logic scan_done;
	} ist_sts_t;

	typedef struct packed {
		logic                     was_present;
		logic                     dropped_full;
		logic [CountW-1:0]        member_count;
		logic                     is_empty;
		logic signed [ValueW-1:0] smallest_member;
		logic signed [ValueW-1:0] largest_member;
	} ist_res_t;

endpackage

// ===== rtl/ist_in_if.sv =====
// ----------------------------------------------------------------------------
// ist_in_if
// operation channel: opcode and operand with valid/ready handshake
// ----------------------------------------------------------------------------
interface ist_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== rtl/ist_out_if.sv =====
// ----------------------------------------------------------------------------
// ist_out_if
// result channel: membership flags, count and extremes with valid/ready
// ----------------------------------------------------------------------------
interface ist_out_if;
	logic               valid;
	logic               ready;
	logic               was_present;
	logic               dropped_full;
	logic [6:0]         member_count;
	logic               is_empty;
	logic signed [31:0] smallest_member;
	logic signed [31:0] largest_member;

	modport source (output valid, output was_present, output dropped_full,
		output member_count, output is_empty, output smallest_member,
		output largest_member, input ready);
	modport sink (input valid, input was_present, input dropped_full,
		input member_count, input is_empty, input smallest_member,
		input largest_member, output ready);
endinterface

// ===== rtl/integer_set_table.sv =====
// ----------------------------------------------------------------------------
// integer_set_table
// bounded set of signed 32-bit integers with add, remove, lookup and clear
// ----------------------------------------------------------------------------
// Each operation returns one result with the prior membership of the value,
// a drop flag for an add refused on a full table, the member count, an empty
// flag and the smallest and largest members (both 0 when empty). Entries sit
// in a single memory in insertion order and every operation but clear walks
// the N current members one per cycle through its read port, matching the
// value, compacting on remove and tracking the extremes. The finished result
// is held in an output register, so the next operation is taken while it
// waits; that operation stalls before its own result for as long as the
// previous one is not read.
module integer_set_table import ist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic       clk,
	input logic       arst_n,
	ist_in_if.sink    cmd,
	ist_out_if.source rsp
);

	ist_ctl_t ctl;
	ist_sts_t sts;
	ist_res_t res;

	ist_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_opcode (cmd.opcode),
		.cmd_ready  (cmd.ready),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.sts        (sts),
		.ctl        (ctl)
	);

	ist_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opcode (cmd.opcode),
		.value  (cmd.value),
		.sts    (sts),
		.res    (res)
	);

	assign rsp.was_present     = res.was_present;
	assign rsp.dropped_full    = res.dropped_full;
	assign rsp.member_count    = res.member_count;
	assign rsp.is_empty        = res.is_empty;
	assign rsp.smallest_member = res.smallest_member;
	assign rsp.largest_member  = res.largest_member;

`ifndef SYNTH
	a_drop_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.dropped_full |-> !rsp.was_present)
		else $error("drop reported for a present value");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_empty |-> (rsp.smallest_member == 0) && (rsp.largest_member == 0))
		else $error("extremes not zero on empty set");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.is_empty |-> rsp.smallest_member <= rsp.largest_member)
		else $error("smallest member above largest");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.start, ctl.scan, ctl.finish}))
		else $error("controller issued overlapping commands");
`endif

endmodule

// ===== rtl/ist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ist_ctrl
// sequencer for one operation: accept, scan the table, commit and post result
// ----------------------------------------------------------------------------
module ist_ctrl import ist_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic [1:0] cmd_opcode,
	output logic       cmd_ready,
	input  logic       rsp_ready,
	output logic       rsp_valid,
	input  ist_sts_t   sts,
	output ist_ctl_t   ctl
);

	ist_state_t state_q;
	ist_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = (ist_op_t'(cmd_opcode) == OP_CLEAR) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctl.start = cmd_valid;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_FINISH: begin
				ctl.finish = out_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== rtl/ist_dpath.sv =====
// ----------------------------------------------------------------------------
// ist_dpath
// entry memory, sequential match scan with compaction, min/max tracking
// ----------------------------------------------------------------------------
module ist_dpath import ist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ist_ctl_t                 ctl,
	input  logic [1:0]               opcode,
	input  logic signed [ValueW-1:0] value,
	output ist_sts_t                 sts,
	output ist_res_t                 res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [ValueW-1:0] mem [CAPACITY];

	ist_op_t                  op_q;
	logic signed [ValueW-1:0] val_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            rd_idx_q;
	logic [AW-1:0]            idx_s1;
	logic signed [ValueW-1:0] rdata_s1;
	logic                     rvalid_s1;
	logic                     found_q;
	logic                     have_q;
	logic signed [ValueW-1:0] lo_q;
	logic signed [ValueW-1:0] hi_q;
	ist_res_t                 res_q;

	logic                     rd_en;
	logic                     hit;
	logic                     shift_wr;
	logic                     incl;
	logic                     room;
	logic                     app;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [ValueW-1:0] wr_data;
	logic [CW-1:0]            cnt_new;
	logic signed [ValueW-1:0] lo_f;
	logic signed [ValueW-1:0] hi_f;

	assign rd_en    = ctl.scan && (rd_idx_q < cnt_q);
	assign hit      = rvalid_s1 && (rdata_s1 == val_q);
	assign shift_wr = rvalid_s1 && found_q && (op_q == OP_REMOVE);
	assign incl     = rvalid_s1 && !(hit && (op_q == OP_REMOVE));
	assign room     = cnt_q < CW'(CAPACITY);
	assign app      = (op_q == OP_ADD) && !found_q && room;
	assign wr_en    = shift_wr || (ctl.finish && app);
	assign wr_addr  = shift_wr ? (idx_s1 - 1'b1) : cnt_q[AW-1:0];
	assign wr_data  = shift_wr ? rdata_s1 : val_q;

	assign sts.scan_done = (rd_idx_q >= cnt_q) && !rvalid_s1;

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_comb begin
		case (op_q)
			OP_ADD:    cnt_new = app ? cnt_q + 1'b1 : cnt_q;
			OP_REMOVE: cnt_new = found_q ? cnt_q - 1'b1 : cnt_q;
			OP_LOOKUP: cnt_new = cnt_q;
			default:   cnt_new = '0;
		endcase
		lo_f = lo_q;
		hi_f = hi_q;
		if (app) begin
			if (!have_q || (val_q < lo_q)) begin
				lo_f = val_q;
			end
			if (!have_q || (val_q > hi_q)) begin
				hi_f = val_q;
			end
		end
		if (cnt_new == '0) begin
			lo_f = '0;
			hi_f = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			if (ctl.finish) begin
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q     <= ist_op_t'(opcode);
			val_q    <= value;
			rd_idx_q <= '0;
			found_q  <= 1'b0;
			have_q   <= 1'b0;
		end else if (ctl.scan) begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				idx_s1   <= rd_idx_q[AW-1:0];
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (incl) begin
				have_q <= 1'b1;
				if (!have_q || (rdata_s1 < lo_q)) begin
					lo_q <= rdata_s1;
				end
				if (!have_q || (rdata_s1 > hi_q)) begin
					hi_q <= rdata_s1;
				end
			end
		end
		if (ctl.finish) begin
			res_q.was_present     <= found_q;
			res_q.dropped_full    <= (op_q == OP_ADD) && !found_q && !room;
			res_q.member_count    <= CountW'(cnt_new);
			res_q.is_empty        <= (cnt_new == '0);
			res_q.smallest_member <= lo_f;
			res_q.largest_member  <= hi_f;
		end
	end

	assign res = res_q;

endmodule
